/* hdl/jet_patch_trigger_combiner_top_macros.svh */
// ----------------------------------------------------------------------------
// jet_patch_trigger_combiner_top_macros
// Assertion helpers for the jet patch trigger combiner.
// ----------------------------------------------------------------------------
`ifndef JET_PATCH_TRIGGER_COMBINER_TOP_MACROS_SVH
`define JET_PATCH_TRIGGER_COMBINER_TOP_MACROS_SVH

// property that must hold on every clock edge out of reset
`define JPTC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("jptc check failed");

// antecedent in one cycle implies consequent in the next
`define JPTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jptc check failed");

`endif

/* hdl/jptc_pkg.sv */
// ----------------------------------------------------------------------------
// jptc_pkg
// Shared types and bit positions for the jet patch trigger combiner.
// ----------------------------------------------------------------------------
package jptc_pkg;

  localparam int unsigned THR_BITS   = 6;
  localparam int unsigned MASK_BITS  = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned NUM_PATCH  = 6;
  localparam int unsigned NUM_THR    = 3;

  // bit positions inside the detector words
  localparam int unsigned LG_BS0_BIT = 24;
  localparam int unsigned LG_BS1_BIT = 25;
  localparam int unsigned LG_BS2_BIT = 26;
  localparam int unsigned LG_HT0_BIT = 27;
  localparam int unsigned LG_HT1_BIT = 28;
  localparam int unsigned SM_HT0_BIT = 20;
  localparam int unsigned SM_HT1_BIT = 21;
  localparam int unsigned SM_BS0_BIT = 30;
  localparam int unsigned SM_BS1_BIT = 31;

  // patch order: south-top, south, south-bottom, north-top, north, north-bottom
  localparam int unsigned PATCH_ST = 0;
  localparam int unsigned PATCH_S  = 1;
  localparam int unsigned PATCH_SB = 2;
  localparam int unsigned PATCH_NT = 3;
  localparam int unsigned PATCH_N  = 4;
  localparam int unsigned PATCH_NB = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_LOW  = 3'd0,
    REG_THR_MID  = 3'd1,
    REG_THR_HIGH = 3'd2,
    REG_DEBUG    = 3'd3,
    REG_COMBO1   = 3'd4,
    REG_COMBO2   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] small_cell_word;
    logic [28:0] south_large_word;
    logic [28:0] north_large_word;
    logic [1:0]  preshower_bits;
  } in_t;

  typedef struct packed {
    logic [1:0] high_tower_bits;
    logic [1:0] small_board_sums;
    logic [2:0] large_board_sums;
    logic [2:0] jet_patch_bits;
    logic       dijet_flag;
    logic [1:0] combo_bits;
    logic       preshower_flag;
  } out_t;

  // bits that bypass the patch arithmetic
  typedef struct packed {
    logic [1:0] ht;
    logic [1:0] sbs;
    logic [2:0] lbs;
    logic       fpe;
  } side_t;

endpackage

/* hdl/jet_patch_trigger_combiner_top.sv */
// ----------------------------------------------------------------------------
// jet_patch_trigger_combiner_top: jet patch sums, thresholds and combinations;
// a slice passes from start to out_valid through the sum / compare / reduce /
// mask register stages; one time slice accepted per cycle, busy stays low
// rst_n (sync) clears the valid pipe and all configuration registers to zero
// ----------------------------------------------------------------------------
`include "jet_patch_trigger_combiner_top_macros.svh"

module jet_patch_trigger_combiner_top #(
  parameter int unsigned SUM_FIELD_BITS = 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  jptc_pkg::in_t                        in_data,
  output logic                                 out_valid,
  output jptc_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jptc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jptc_pkg::MASK_BITS-1:0]       cfg_data
);

  localparam int unsigned SW = SUM_FIELD_BITS + 1;
  localparam int unsigned CW = (SW > jptc_pkg::THR_BITS) ? SW : jptc_pkg::THR_BITS;

  // configuration
  logic [jptc_pkg::THR_BITS-1:0]  thr_r [jptc_pkg::NUM_THR];
  logic                           debug_r;
  logic [jptc_pkg::MASK_BITS-1:0] combo1_mask_r;
  logic [jptc_pkg::MASK_BITS-1:0] combo2_mask_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r[0]      <= '0;
      thr_r[1]      <= '0;
      thr_r[2]      <= '0;
      debug_r       <= 1'b0;
      combo1_mask_r <= '0;
      combo2_mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (jptc_pkg::cfg_reg_t'(cfg_index))
        jptc_pkg::REG_THR_LOW:  thr_r[0] <= cfg_data[jptc_pkg::THR_BITS-1:0];
        jptc_pkg::REG_THR_MID:  thr_r[1] <= cfg_data[jptc_pkg::THR_BITS-1:0];
        jptc_pkg::REG_THR_HIGH: thr_r[2] <= cfg_data[jptc_pkg::THR_BITS-1:0];
        jptc_pkg::REG_DEBUG:    debug_r  <= cfg_data[0];
        jptc_pkg::REG_COMBO1:   combo1_mask_r <= cfg_data;
        jptc_pkg::REG_COMBO2:   combo2_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: patch sums and side bits
  logic [63:0]         sm_ext, so_ext, no_ext;
  logic [SW-1:0]       sum_nxt [jptc_pkg::NUM_PATCH];
  jptc_pkg::side_t     side_nxt;
  logic                v1_r;
  logic [SW-1:0]       sum_r [jptc_pkg::NUM_PATCH];
  jptc_pkg::side_t     side1_r;

  // zero padding keeps wide fields beyond the word at zero
  assign sm_ext = {32'b0, in_data.small_cell_word};
  assign so_ext = {35'b0, in_data.south_large_word};
  assign no_ext = {35'b0, in_data.north_large_word};

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      sum_nxt[p]   = {1'b0, sm_ext[p*SUM_FIELD_BITS +: SUM_FIELD_BITS]}
                   + {1'b0, so_ext[p*SUM_FIELD_BITS +: SUM_FIELD_BITS]};
      sum_nxt[p+3] = {1'b0, sm_ext[(p+3)*SUM_FIELD_BITS +: SUM_FIELD_BITS]}
                   + {1'b0, no_ext[p*SUM_FIELD_BITS +: SUM_FIELD_BITS]};
    end
    side_nxt.ht[0] = so_ext[jptc_pkg::LG_HT0_BIT] | no_ext[jptc_pkg::LG_HT0_BIT]
                   | (debug_r & sm_ext[jptc_pkg::SM_HT0_BIT]);
    side_nxt.ht[1] = so_ext[jptc_pkg::LG_HT1_BIT] | no_ext[jptc_pkg::LG_HT1_BIT]
                   | (debug_r & sm_ext[jptc_pkg::SM_HT1_BIT]);
    side_nxt.sbs   = {sm_ext[jptc_pkg::SM_BS1_BIT], sm_ext[jptc_pkg::SM_BS0_BIT]};
    side_nxt.lbs   = {so_ext[jptc_pkg::LG_BS2_BIT] | no_ext[jptc_pkg::LG_BS2_BIT],
                      so_ext[jptc_pkg::LG_BS1_BIT] | no_ext[jptc_pkg::LG_BS1_BIT],
                      so_ext[jptc_pkg::LG_BS0_BIT] | no_ext[jptc_pkg::LG_BS0_BIT]};
    side_nxt.fpe   = |in_data.preshower_bits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    sum_r   <= sum_nxt;
    side1_r <= side_nxt;
  end

  // stage 2: threshold compares
  logic [jptc_pkg::NUM_THR-1:0][jptc_pkg::NUM_PATCH-1:0] over_nxt, over_r;
  logic            v2_r;
  jptc_pkg::side_t side2_r;

  always_comb begin
    for (int i = 0; i < jptc_pkg::NUM_THR; i++) begin
      for (int p = 0; p < jptc_pkg::NUM_PATCH; p++) begin
        over_nxt[i][p] = CW'(sum_r[p]) > CW'(thr_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    over_r  <= over_nxt;
    side2_r <= side1_r;
  end

  // stage 3: jet patch bits, di-jet and trigger terms
  logic [jptc_pkg::NUM_PATCH-1:0] incl_mask;
  logic [2:0]                     jp_nxt, jp_r;
  logic                           dijet_nxt, dijet_r;
  logic [jptc_pkg::NUM_PATCH-1:0] o0;
  logic [jptc_pkg::MASK_BITS-1:0] terms_nxt, terms_r;
  logic                           v3_r;
  jptc_pkg::side_t                side3_r;

  always_comb begin
    incl_mask = '1;
    incl_mask[jptc_pkg::PATCH_N] = !debug_r;   // north patch dropped in debug
    for (int i = 0; i < jptc_pkg::NUM_THR; i++) begin
      jp_nxt[i] = |(over_r[i] & incl_mask);
    end
    o0 = over_r[0];
    dijet_nxt = (o0[jptc_pkg::PATCH_ST] & (o0[jptc_pkg::PATCH_SB] | o0[jptc_pkg::PATCH_NT]
                                          | o0[jptc_pkg::PATCH_NB]))
              | (o0[jptc_pkg::PATCH_SB] & (o0[jptc_pkg::PATCH_NT] | o0[jptc_pkg::PATCH_NB]))
              | (o0[jptc_pkg::PATCH_NT] & o0[jptc_pkg::PATCH_NB])
              | (o0[jptc_pkg::PATCH_N]  & (o0[jptc_pkg::PATCH_ST] | o0[jptc_pkg::PATCH_S]
                                          | o0[jptc_pkg::PATCH_SB]))
              | (o0[jptc_pkg::PATCH_S]  & (o0[jptc_pkg::PATCH_NT] | o0[jptc_pkg::PATCH_NB]));
    terms_nxt = {side2_r.fpe, dijet_nxt, jp_nxt, side2_r.lbs, side2_r.sbs};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    jp_r    <= jp_nxt;
    dijet_r <= dijet_nxt;
    terms_r <= terms_nxt;
    side3_r <= side2_r;
  end

  // stage 4: masked combinations into the output register
  logic           v4_r;
  jptc_pkg::out_t out_nxt, out_r;

  always_comb begin
    out_nxt.high_tower_bits  = side3_r.ht;
    out_nxt.small_board_sums = side3_r.sbs;
    out_nxt.large_board_sums = side3_r.lbs;
    out_nxt.jet_patch_bits   = jp_r;
    out_nxt.dijet_flag       = dijet_r;
    out_nxt.combo_bits       = {|(terms_r & combo2_mask_r), |(terms_r & combo1_mask_r)};
    out_nxt.preshower_flag   = side3_r.fpe;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    out_r <= out_nxt;
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

  `JPTC_ASSERT(a_start_to_out, start |-> ##4 out_valid)
  `JPTC_ASSERT(a_idle_no_out, !start |-> ##4 !out_valid)
  `JPTC_ASSERT(a_dijet_has_patch, (out_valid && out_data.dijet_flag) |->
                                  out_data.jet_patch_bits[0])
  `JPTC_ASSERT_NEXT(a_combo1_off, (v3_r && combo1_mask_r == '0 && !cfg_valid),
                    !out_data.combo_bits[0])

endmodule

/* dv/tb_jet_patch_trigger_combiner_top.sv */
// ----------------------------------------------------------------------------
// tb_jet_patch_trigger_combiner_top
// Self-checking bench for the jet patch trigger combiner: a scoreboard class
// predicts each trigger word from the accepted time slice and the register
// settings it has seen written, then checks every strobed result in order.
// ----------------------------------------------------------------------------
module tb_jet_patch_trigger_combiner_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SUM_W       = 5;
  localparam int unsigned THR_W       = jptc_pkg::THR_BITS;
  localparam int unsigned MASK_W      = jptc_pkg::MASK_BITS;
  localparam int unsigned IDLE_PCT    = 34;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 110;

  // expected trigger words and the register copy that shapes them
  class trigger_ledger;
    logic [THR_W-1:0]  thr [jptc_pkg::NUM_THR];
    logic              debug = 1'b0;
    logic [MASK_W-1:0] mask_one = '0;
    logic [MASK_W-1:0] mask_two = '0;
    jptc_pkg::out_t    pending_triggers [$];
    int                errors = 0;

    function new();
      foreach (thr[i]) thr[i] = '0;
    endfunction

    function void set_reg(jptc_pkg::cfg_reg_t idx, logic [MASK_W-1:0] val);
      case (idx)
        jptc_pkg::REG_THR_LOW:  thr[0] = val[THR_W-1:0];
        jptc_pkg::REG_THR_MID:  thr[1] = val[THR_W-1:0];
        jptc_pkg::REG_THR_HIGH: thr[2] = val[THR_W-1:0];
        jptc_pkg::REG_DEBUG:    debug = val[0];
        jptc_pkg::REG_COMBO1:   mask_one = val;
        jptc_pkg::REG_COMBO2:   mask_two = val;
        default: ;
      endcase
    endfunction

    function jptc_pkg::out_t calc_trigger(jptc_pkg::in_t s);
      jptc_pkg::out_t               r;
      int unsigned                  sum [jptc_pkg::NUM_PATCH];
      logic                         over [jptc_pkg::NUM_THR][jptc_pkg::NUM_PATCH];
      logic [jptc_pkg::NUM_PATCH-1:0] o0;
      logic [2:0]                   jp;
      logic                         dj;
      logic [MASK_W-1:0]            terms;
      r = '0;
      jp = '0;
      r.high_tower_bits[0] = s.south_large_word[jptc_pkg::LG_HT0_BIT]
                           | s.north_large_word[jptc_pkg::LG_HT0_BIT];
      r.high_tower_bits[1] = s.south_large_word[jptc_pkg::LG_HT1_BIT]
                           | s.north_large_word[jptc_pkg::LG_HT1_BIT];
      if (debug) begin
        r.high_tower_bits[0] |= s.small_cell_word[jptc_pkg::SM_HT0_BIT];
        r.high_tower_bits[1] |= s.small_cell_word[jptc_pkg::SM_HT1_BIT];
      end
      r.small_board_sums = {s.small_cell_word[jptc_pkg::SM_BS1_BIT],
                            s.small_cell_word[jptc_pkg::SM_BS0_BIT]};
      r.large_board_sums = {s.south_large_word[jptc_pkg::LG_BS2_BIT]
                              | s.north_large_word[jptc_pkg::LG_BS2_BIT],
                            s.south_large_word[jptc_pkg::LG_BS1_BIT]
                              | s.north_large_word[jptc_pkg::LG_BS1_BIT],
                            s.south_large_word[jptc_pkg::LG_BS0_BIT]
                              | s.north_large_word[jptc_pkg::LG_BS0_BIT]};
      r.preshower_flag = |s.preshower_bits;
      for (int p = 0; p < jptc_pkg::NUM_PATCH; p++) begin
        if (p < 3)
          sum[p] = 32'(s.small_cell_word[p*SUM_W +: SUM_W])
                 + 32'(s.south_large_word[p*SUM_W +: SUM_W]);
        else
          sum[p] = 32'(s.small_cell_word[p*SUM_W +: SUM_W])
                 + 32'(s.north_large_word[(p-3)*SUM_W +: SUM_W]);
      end
      for (int i = 0; i < jptc_pkg::NUM_THR; i++) begin
        for (int p = 0; p < jptc_pkg::NUM_PATCH; p++) begin
          over[i][p] = (sum[p] > 32'(thr[i]));
          // north patch drops out of the threshold bits in debug mode only
          if (over[i][p] && !(p == jptc_pkg::PATCH_N && debug)) jp[i] = 1'b1;
        end
      end
      for (int p = 0; p < jptc_pkg::NUM_PATCH; p++) o0[p] = over[0][p];
      dj = (o0[jptc_pkg::PATCH_ST] & (o0[jptc_pkg::PATCH_SB] | o0[jptc_pkg::PATCH_NT]
                                      | o0[jptc_pkg::PATCH_NB]))
         | (o0[jptc_pkg::PATCH_SB] & (o0[jptc_pkg::PATCH_NT] | o0[jptc_pkg::PATCH_NB]))
         | (o0[jptc_pkg::PATCH_NT] & o0[jptc_pkg::PATCH_NB])
         | (o0[jptc_pkg::PATCH_N]  & (o0[jptc_pkg::PATCH_ST] | o0[jptc_pkg::PATCH_S]
                                      | o0[jptc_pkg::PATCH_SB]))
         | (o0[jptc_pkg::PATCH_S]  & (o0[jptc_pkg::PATCH_NT] | o0[jptc_pkg::PATCH_NB]));
      r.jet_patch_bits = jp;
      r.dijet_flag = dj;
      terms = {r.preshower_flag, dj, jp, r.large_board_sums, r.small_board_sums};
      r.combo_bits = {|(terms & mask_two), |(terms & mask_one)};
      return r;
    endfunction

    function void note_slice(jptc_pkg::in_t s);
      pending_triggers.push_back(calc_trigger(s));
    endfunction

    function void cmp_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_trigger(jptc_pkg::out_t got);
      jptc_pkg::out_t exp;
      if (pending_triggers.size() == 0) begin
        $error("result transfer with no expected trigger word pending");
        errors++;
        return;
      end
      exp = pending_triggers.pop_front();
      cmp_field("high_tower_bits", 32'(exp.high_tower_bits), 32'(got.high_tower_bits));
      cmp_field("small_board_sums", 32'(exp.small_board_sums), 32'(got.small_board_sums));
      cmp_field("large_board_sums", 32'(exp.large_board_sums), 32'(got.large_board_sums));
      cmp_field("jet_patch_bits", 32'(exp.jet_patch_bits), 32'(got.jet_patch_bits));
      cmp_field("dijet_flag", 32'(exp.dijet_flag), 32'(got.dijet_flag));
      cmp_field("combo_bits", 32'(exp.combo_bits), 32'(got.combo_bits));
      cmp_field("preshower_flag", 32'(exp.preshower_flag), 32'(got.preshower_flag));
    endfunction

    function int pending();
      return pending_triggers.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  jptc_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  jptc_pkg::out_t                 out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [jptc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASK_W-1:0]              cfg_data = '0;

  trigger_ledger ledger = new;

  always #4 clk = ~clk;

  jet_patch_trigger_combiner_top #(
    .SUM_FIELD_BITS(SUM_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // transfer monitor: results first, then new slices and register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) ledger.check_trigger(out_data);
      if (start && !busy) ledger.note_slice(in_data);
      if (cfg_valid && cfg_ready) ledger.set_reg(jptc_pkg::cfg_reg_t'(cfg_index), cfg_data);
    end
  end

  function automatic jptc_pkg::in_t patch_slice(int unsigned patch, logic [SUM_W-1:0] sm_part,
                                                logic [SUM_W-1:0] lg_part);
    jptc_pkg::in_t v;
    v = '0;
    v.small_cell_word[patch*SUM_W +: SUM_W] = sm_part;
    if (patch < 3) v.south_large_word[patch*SUM_W +: SUM_W] = lg_part;
    else v.north_large_word[(patch-3)*SUM_W +: SUM_W] = lg_part;
    return v;
  endfunction

  function automatic jptc_pkg::in_t rand_slice();
    jptc_pkg::in_t v;
    int            n;
    if ($urandom_range(0, 1) == 0) begin
      v.small_cell_word  = $urandom;
      v.south_large_word = 29'($urandom);
      v.north_large_word = 29'($urandom);
      v.preshower_bits   = 2'($urandom);
    end else begin
      // sparse slice: a few lit patches so thresholds and pairs get exercised
      v.small_cell_word  = $urandom & 32'hC000_0000;
      v.south_large_word = 29'($urandom) & 29'h1F00_0000;
      v.north_large_word = 29'($urandom) & 29'h1F00_0000;
      v.preshower_bits   = 2'($urandom);
      n = $urandom_range(1, 3);
      repeat (n) v = v | patch_slice($urandom_range(0, jptc_pkg::NUM_PATCH-1),
                                     SUM_W'($urandom_range(0, 31)),
                                     SUM_W'($urandom_range(0, 31)));
    end
    return v;
  endfunction

  function automatic logic [THR_W-1:0] pick_thr();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return THR_W'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return MASK_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic set_regs(logic [THR_W-1:0] t_low, logic [THR_W-1:0] t_mid,
                          logic [THR_W-1:0] t_high, logic dbg,
                          logic [MASK_W-1:0] m_one, logic [MASK_W-1:0] m_two);
    jptc_pkg::cfg_reg_t regs [6];
    logic [MASK_W-1:0]  vals [6];
    regs = '{jptc_pkg::REG_THR_LOW, jptc_pkg::REG_THR_MID, jptc_pkg::REG_THR_HIGH,
             jptc_pkg::REG_DEBUG, jptc_pkg::REG_COMBO1, jptc_pkg::REG_COMBO2};
    vals = '{MASK_W'(t_low), MASK_W'(t_mid), MASK_W'(t_high), MASK_W'(dbg),
             m_one, m_two};
    for (int i = 0; i < 6; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_slice(jptc_pkg::in_t v, bit allow_idle);
    while (allow_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    // wait on the clock first so the last accepted slice is already noted
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  initial begin
    jptc_pkg::in_t ones;
    ones.small_cell_word  = '1;
    ones.south_large_word = '1;
    ones.north_large_word = '1;
    ones.preshower_bits   = '1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: everything zero
    send_slice('0, 1'b1);
    send_slice(ones, 1'b1);
    drain();

    set_regs(6'd10, 6'd30, 6'd61, 1'b0, 10'h155, 10'h2AA);
    send_slice(patch_slice(jptc_pkg::PATCH_ST, 5'd5, 5'd5), 1'b1);    // equal to threshold
    send_slice(patch_slice(jptc_pkg::PATCH_ST, 5'd6, 5'd5), 1'b1);    // one above
    send_slice(patch_slice(jptc_pkg::PATCH_S, 5'd31, 5'd0), 1'b1);
    send_slice(patch_slice(jptc_pkg::PATCH_NB, 5'd31, 5'd31), 1'b1);  // largest sum
    send_slice(patch_slice(jptc_pkg::PATCH_ST, 5'd6, 5'd5)
               | patch_slice(jptc_pkg::PATCH_S, 5'd11, 5'd0), 1'b1);
    send_slice(patch_slice(jptc_pkg::PATCH_ST, 5'd11, 5'd0)
               | patch_slice(jptc_pkg::PATCH_SB, 5'd0, 5'd11), 1'b1);
    send_slice(patch_slice(jptc_pkg::PATCH_N, 5'd20, 5'd0)
               | patch_slice(jptc_pkg::PATCH_S, 5'd0, 5'd20), 1'b1);
    send_slice(patch_slice(jptc_pkg::PATCH_NT, 5'd15, 5'd15)
               | patch_slice(jptc_pkg::PATCH_NB, 5'd31, 5'd1), 1'b1);
    send_slice(jptc_pkg::in_t'({32'h0, 29'h0, 29'h0, 2'b01}), 1'b1);
    send_slice(jptc_pkg::in_t'({32'h0, 29'h0, 29'h0, 2'b10}), 1'b1);
    send_slice(jptc_pkg::in_t'({32'h0, 29'h0800_0000, 29'h0, 2'b00}), 1'b1);
    send_slice(jptc_pkg::in_t'({32'h0, 29'h0, 29'h1000_0000, 2'b00}), 1'b1);
    send_slice(jptc_pkg::in_t'({32'hC000_0000, 29'h0, 29'h0, 2'b00}), 1'b1);
    send_slice(jptc_pkg::in_t'({32'h0, 29'h0500_0000, 29'h0200_0000, 2'b00}), 1'b1);
    drain();

    // debug mode: north patch leaves the threshold bits but not the pairs
    set_regs(6'd10, 6'd30, 6'd61, 1'b1, 10'h3FF, 10'h3FF);
    send_slice(patch_slice(jptc_pkg::PATCH_N, 5'd31, 5'd31), 1'b1);
    send_slice(patch_slice(jptc_pkg::PATCH_N, 5'd31, 5'd0)
               | patch_slice(jptc_pkg::PATCH_ST, 5'd0, 5'd12), 1'b1);
    send_slice(jptc_pkg::in_t'({32'h0010_0000, 29'h0, 29'h0, 2'b00}), 1'b1);
    send_slice(jptc_pkg::in_t'({32'h0020_0000, 29'h0, 29'h0, 2'b00}), 1'b1);
    drain();

    set_regs('1, '1, '1, 1'b0, '0, '0);
    send_slice(ones, 1'b1);
    drain();

    set_regs('0, '0, '0, 1'b1, '1, '1);
    send_slice('0, 1'b1);
    send_slice(patch_slice(jptc_pkg::PATCH_ST, 5'd1, 5'd0), 1'b1);
    send_slice(ones, 1'b1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_regs('0, '0, '0, 1'b1, '1, '0);
        1: set_regs('1, '1, '1, 1'b0, '0, '1);
        default: set_regs(pick_thr(), pick_thr(), pick_thr(), 1'($urandom_range(0, 1)),
                          pick_mask(), pick_mask());
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS/2) drain();
        // phase two runs back to back with no gaps
        send_slice(rand_slice(), ph != 2);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
